[hdl/tlru_pkg.sv]
// Shared types and constants for the true LRU way selector.
// Stream payload layout and item opcodes; no dependencies.
package tlru_pkg;

    // Field widths of one transaction
    localparam int SET_W    = 6;
    localparam int WAY_W    = 2;
    localparam int VICTIM_W = 2;

    // Stream bus widths (payload padded to whole bytes)
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    // Item kinds carried on the slave-side tuser
    typedef enum logic [0:0] {
        OP_TOUCH = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

endpackage

[hdl/true_lru_way_selector_core.sv]
// Top level of the true LRU way selector.
// Uses tlru_pkg, tlru_ram (recency rows) and tlru_row_update (stack update).
//
// Usage:
//   Slave channel: tdata = set_index[5:0], way[7:6]; tuser[0] = opcode
//   (touch or query). Master channel: tdata = victim_way[1:0] (zero padded);
//   tuser[0] = range_error. Every transaction in gives exactly one out, in order.
//   Accepted transactions pass the update stage registers, then the output
//   register. Throughput: one transaction per cycle while the master side
//   does not stall. Each item reads its set's row from the single-read-port
//   RAM in the accept cycle; the stage after it updates the row, writes it
//   back and loads the output register. An item of the same set accepted
//   with that write takes the updated row from a bypass register, not the RAM.
//   Reset: a per-set valid flag is cleared, so every set reads as position j
//   holding way j until first written; no clearing pass, items are taken as
//   soon as reset is released.
//   Stall: while the master side holds tready low the output register keeps
//   its transaction, one more item waits in the update stage, and tready on
//   the slave side then drops until the output register drains.
module true_lru_way_selector_core #(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Slave side
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [tlru_pkg::S_TDATA_W-1:0] i_s_tdata,  // set_index[5:0], way[7:6]
    input  logic [tlru_pkg::S_TUSER_W-1:0] i_s_tuser,  // opcode[0]
    // Master side
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [tlru_pkg::M_TDATA_W-1:0] o_m_tdata,  // victim_way[1:0], zeros above
    output logic [tlru_pkg::M_TUSER_W-1:0] o_m_tuser   // range_error[0]
);

    import tlru_pkg::*;

    localparam int WW      = $clog2(WAYS);
    localparam int RW      = WAYS * WW;
    localparam int MAX_SET = 1 << SET_W;
    localparam int DEPTH   = (SETS < MAX_SET) ? SETS : MAX_SET;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Input unpacking
    logic [SET_W-1:0] in_set;
    logic [WAY_W-1:0] in_way;
    t_opcode          in_op;
    logic [AW-1:0]    in_addr;

    // Update stage registers
    logic             r_s1_vld;
    t_opcode          r_op;
    logic [SET_W-1:0] r_set;
    logic [WAY_W-1:0] r_way;
    logic             r_byp;
    logic [RW-1:0]    r_byp_row;
    logic [DEPTH-1:0] r_row_vld;
    logic [DEPTH-1:0] n_row_vld;

    // Output register
    logic                r_o_vld;
    logic [VICTIM_W-1:0] r_victim;
    logic                r_err;

    // Stage logic
    logic                s_accept;
    logic                s1_fire;
    logic                out_free;
    logic [AW-1:0]       r_addr;
    logic [RW-1:0]       ram_rdata;
    logic [RW-1:0]       rst_row;
    logic [RW-1:0]       cur_row;
    logic [RW-1:0]       upd_row;
    logic [RW-1:0]       new_row;
    logic                set_ok;
    logic                way_ok;
    logic                is_touch;
    logic                do_write;
    logic                ram_we;
    logic [VICTIM_W-1:0] victim;
    logic                err;
    logic [WAYS-1:0]     way_seen;

    assign in_set  = i_s_tdata[SET_W-1:0];
    assign in_way  = i_s_tdata[SET_W +: WAY_W];
    assign in_op   = t_opcode'(i_s_tuser[0]);
    assign in_addr = AW'(in_set);
    assign r_addr  = AW'(r_set);

    // Handshake: stage 1 moves when the output register is free
    assign out_free   = !r_o_vld || i_m_tready;
    assign s1_fire    = r_s1_vld && out_free;
    assign o_s_tready = !r_s1_vld || s1_fire;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Row after reset: position j holds way j
    always_comb begin
        for (int p = 0; p < WAYS; p++) begin
            rst_row[p*WW +: WW] = WW'(p);
        end
    end

    // Select the current row: bypass, stored row, or the reset order
    always_comb begin
        if (r_byp) begin
            cur_row = r_byp_row;
        end else if (r_row_vld[r_addr]) begin
            cur_row = ram_rdata;
        end else begin
            cur_row = rst_row;
        end
    end

    tlru_row_update #(
        .WAYS (WAYS)
    ) u_row_update (
        .i_row (cur_row),
        .i_way (WW'(r_way)),
        .o_row (upd_row)
    );

    // Range checks and result
    assign set_ok   = int'(r_set) < SETS;
    assign way_ok   = int'(r_way) < WAYS;
    assign is_touch = (r_op == OP_TOUCH);
    assign do_write = set_ok && is_touch && way_ok;
    assign ram_we   = s1_fire && do_write;
    assign new_row  = do_write ? upd_row : cur_row;
    assign victim   = set_ok ? VICTIM_W'(new_row[(WAYS-1)*WW +: WW]) : '0;
    assign err      = !set_ok || (is_touch && !way_ok);

    // Mark a set's row valid once written
    always_comb begin
        n_row_vld = r_row_vld;
        if (ram_we) begin
            n_row_vld[r_addr] = 1'b1;
        end
    end

    tlru_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (upd_row),
        .i_re    (s_accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_o_vld   <= 1'b0;
            r_byp     <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_row_vld <= n_row_vld;
            if (o_s_tready) begin
                r_s1_vld <= i_s_tvalid;
            end
            if (s_accept) begin
                r_byp <= ram_we && (in_addr == r_addr);
            end
            if (out_free) begin
                r_o_vld <= r_s1_vld;
            end
        end
    end

    // Payload: capture the transaction, bypass row and result
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op      <= in_op;
            r_set     <= in_set;
            r_way     <= in_way;
            r_byp_row <= upd_row;
        end
        if (s1_fire) begin
            r_victim <= victim;
            r_err    <= err;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = M_TDATA_W'(r_victim);
    assign o_m_tuser  = M_TUSER_W'(r_err);

    // Each way occurs in the row under update
    always_comb begin
        for (int k = 0; k < WAYS; k++) begin
            way_seen[k] = 1'b0;
            for (int p = 0; p < WAYS; p++) begin
                way_seen[k] = way_seen[k] | (cur_row[p*WW +: WW] == WW'(k));
            end
        end
    end

    // A row written at the accept edge of the same set must be bypassed
    a_bypass_same_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(ram_we) && $past(s_accept) && $past(r_addr) == $past(in_addr)) |-> r_byp)
        else $error("same-set back-to-back touch missed the bypass");

    // The recency row stays a permutation of the ways
    a_row_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && set_ok) |-> (&way_seen))
        else $error("recency row is not a permutation of the ways");

    // An out-of-range set reports victim zero with the error flag
    a_bad_set_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !set_ok) |=> (r_err && r_victim == '0))
        else $error("out-of-range set gave a wrong result");

endmodule

[hdl/tlru_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Holds the per-set recency rows; no package dependencies.
module tlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/tlru_row_update.sv]
// Recency row update: move the touched way to the front of one set's stack.
// Pure combinational; no package dependencies.
module tlru_row_update #(
    parameter int WAYS = 4,
    localparam int WW = $clog2(WAYS),
    localparam int RW = WAYS * WW
) (
    input  logic [RW-1:0] i_row,
    input  logic [WW-1:0] i_way,
    output logic [RW-1:0] o_row
);

    logic [WAYS-1:0] hit_before;

    // Flag positions that lie behind the touched way's old slot
    always_comb begin
        hit_before[0] = 1'b0;
        for (int p = 1; p < WAYS; p++) begin
            hit_before[p] = hit_before[p-1] | (i_row[(p-1)*WW +: WW] == i_way);
        end
    end

    // Put the way in front, shift the entries ahead of its old slot back by one
    always_comb begin
        o_row[0 +: WW] = i_way;
        for (int p = 1; p < WAYS; p++) begin
            o_row[p*WW +: WW] = hit_before[p] ? i_row[p*WW +: WW]
                                              : i_row[(p-1)*WW +: WW];
        end
    end

endmodule

[tb/tlru_victim_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the true LRU way selector: keeps its own recency stacks,
// predicts the victim for every slave-side transaction and compares master-side results.
// Depends on tlru_pkg for field widths and the opcode enum.
module tlru_victim_checker #(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [tlru_pkg::S_TDATA_W-1:0] i_s_tdata,  // set_index[5:0], way[7:6]
    input  logic [tlru_pkg::S_TUSER_W-1:0] i_s_tuser,  // opcode[0]
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [tlru_pkg::M_TDATA_W-1:0] i_m_tdata,  // victim_way[1:0], zeros above
    input  logic [tlru_pkg::M_TUSER_W-1:0] i_m_tuser,  // range_error[0]
    output int                             o_fail_count,
    output int                             o_pending
);
    import tlru_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [VICTIM_W-1:0] victim_way;
        logic                range_error;
    } t_victim_result;

    // Recency stack per set, position 0 is the most recently used way
    logic [WAY_W-1:0] recency_rows [SETS][WAYS];
    t_victim_result   victim_queue [$];
    int               mismatch_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Apply one item to the stacks and return the victim it reports
    function automatic t_victim_result apply_item(t_opcode op, int unsigned set_idx,
                                                  int unsigned way_num);
        t_victim_result res;
        int             pos;
        int             p;
        res = '0;
        if (set_idx >= SETS) begin
            res.range_error = 1'b1;
            return res;
        end
        if (op == OP_TOUCH && way_num >= WAYS) begin
            res.range_error = 1'b1;
        end else if (op == OP_TOUCH) begin
            // Locate the way; a missing way drops the last entry
            pos = WAYS - 1;
            for (p = WAYS - 1; p >= 0; p--) begin
                if (recency_rows[set_idx][p] == way_num)
                    pos = p;
            end
            for (p = pos; p > 0; p--)
                recency_rows[set_idx][p] = recency_rows[set_idx][p-1];
            recency_rows[set_idx][0] = WAY_W'(way_num);
        end
        res.victim_way = recency_rows[set_idx][WAYS-1];
        return res;
    endfunction

    function automatic void flag_mismatch(string what, int exp_val, int got_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what,
                     exp_val, got_val);
    endfunction

    // Compare results first, then predict the transaction accepted at this edge
    always @(posedge i_clk) begin
        t_victim_result              exp_res;
        logic [M_TDATA_W-1:0]        exp_tdata;
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++)
                for (int p = 0; p < WAYS; p++)
                    recency_rows[s][p] = WAY_W'(p);
            victim_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (victim_queue.size() == 0) begin
                    flag_mismatch("unexpected transaction, tdata", -1, int'(i_m_tdata));
                end else begin
                    exp_res   = victim_queue.pop_front();
                    exp_tdata = M_TDATA_W'(exp_res.victim_way);
                    if (i_m_tdata !== exp_tdata)
                        flag_mismatch("victim_way (tdata)", int'(exp_tdata), int'(i_m_tdata));
                    if (i_m_tuser[0] !== exp_res.range_error)
                        flag_mismatch("range_error", int'(exp_res.range_error),
                                      int'(i_m_tuser[0]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                victim_queue.push_back(apply_item(t_opcode'(i_s_tuser[0]),
                                                  32'(i_s_tdata[SET_W-1:0]),
                                                  32'(i_s_tdata[SET_W+WAY_W-1:SET_W])));
            end
        end
        o_pending    <= victim_queue.size();
        o_fail_count <= mismatch_count;
    end

endmodule

[tb/true_lru_way_selector_core_tb.sv]
`timescale 1ns / 100ps
// Testbench top for true_lru_way_selector_core: clock, reset, stimulus, backpressure
// and verdict. Depends on tlru_pkg, the block and tlru_victim_checker.
module true_lru_way_selector_core_tb;
    import tlru_pkg::*;

    localparam int WAYS          = 4;
    localparam int SETS          = 64;
    localparam int PHASE_ITEMS   = 470;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 10;
    localparam int WATCHDOG_MAX  = 4000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic [S_TUSER_W-1:0]  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [M_TUSER_W-1:0]  o_m_tuser;

    int fail_count;
    int pending_results;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int idle_cycles    = 0;
    int last_set       = 0;

    true_lru_way_selector_core #(
        .WAYS(WAYS),
        .SETS(SETS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    tlru_victim_checker #(
        .WAYS(WAYS),
        .SETS(SETS)
    ) u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending_results)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when requested
    initial begin
        int hold_left;
        hold_left  = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item and hold it until accepted; returns at a falling edge
    task automatic send_item(t_opcode op, int unsigned set_idx, int unsigned way_num);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {way_num[WAY_W-1:0], set_idx[SET_W-1:0]};
        last_set    = set_idx;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Stop offering until every expected result has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge i_clk);
    endtask

    // Random item, biased to a few hot sets and repeats of the last set
    task automatic send_random_item();
        t_opcode     op;
        int unsigned set_idx;
        int unsigned pick;
        op   = ($urandom_range(99) < 25) ? OP_QUERY : OP_TOUCH;
        pick = $urandom_range(99);
        if (pick < 40)
            set_idx = $urandom_range(3);
        else if (pick < 60)
            set_idx = last_set;
        else
            set_idx = $urandom_range(SETS - 1);
        send_item(op, set_idx, $urandom_range(WAYS - 1));
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_TOUCH;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: front-way touch, full rotation, back-to-back same set, extremes
        send_item(OP_QUERY, 0, 3);
        send_item(OP_TOUCH, 0, 0);
        send_item(OP_TOUCH, 0, 3);
        send_item(OP_TOUCH, 0, 3);
        send_item(OP_TOUCH, 0, 2);
        send_item(OP_TOUCH, 0, 1);
        send_item(OP_TOUCH, 0, 0);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_TOUCH, 63, 3);
        send_item(OP_TOUCH, 63, 2);
        send_item(OP_TOUCH, 63, 1);
        send_item(OP_TOUCH, 63, 0);
        send_item(OP_QUERY, 63, 2);
        send_item(OP_TOUCH, 1, 1);
        send_item(OP_TOUCH, 2, 2);
        send_item(OP_TOUCH, 1, 3);
        send_item(OP_TOUCH, 2, 0);
        send_item(OP_TOUCH, 42, 1);
        send_item(OP_TOUCH, 21, 2);
        send_item(OP_QUERY, 21, 1);
        send_item(OP_QUERY, 42, 3);

        // Random phases: no idling, idle sender, stalling receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 88 : (ph == 3) ? 15 : 0;
            recv_stall_pct = (ph == 2) ? 88 : (ph == 3) ? 15 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 200)
                    hold_req = 1'b1;
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                send_random_item();
            end
        end

        // Wait for the tail, then allow extra time for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hdl/tlru_pkg.sv
hdl/tlru_ram.sv
hdl/tlru_row_update.sv
hdl/true_lru_way_selector_core.sv
tb/tlru_victim_checker.sv
tb/true_lru_way_selector_core_tb.sv
